// File: rtl/sccb_pkg.sv
// Package: shared types, codes and step table of the SCCB register access master.
package sccb_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_DEV_ADDR    = 1'b1;

    // Configuration reset values
    localparam logic [7:0] PHASE_TICKS_RST = 8'd4;
    localparam logic [6:0] DEV_ADDR_RST    = 7'd48;

    // Byte position within a transaction
    localparam logic [2:0] BYTE_ADDR  = 3'd0;
    localparam logic [2:0] BYTE_REG   = 3'd1;
    localparam logic [2:0] BYTE_VALUE = 3'd2;
    localparam logic [2:0] BYTE_RADDR = 3'd3;
    localparam logic [2:0] BYTE_END   = 3'd4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Line action codes for each step
    localparam logic [1:0] LV_LOW  = 2'd0;
    localparam logic [1:0] LV_HIGH = 2'd1;
    localparam logic [1:0] LV_KEEP = 2'd2;
    localparam logic [1:0] LV_DATA = 2'd3;

    typedef enum logic [23:0] {
        PH_IDLE = 24'h000001,
        PH_S0   = 24'h000002,
        PH_S1   = 24'h000004,
        PH_S2   = 24'h000008,
        PH_S3   = 24'h000010,
        PH_B0   = 24'h000020,
        PH_B1   = 24'h000040,
        PH_B2   = 24'h000080,
        PH_A0   = 24'h000100,
        PH_A1   = 24'h000200,
        PH_A2   = 24'h000400,
        PH_A3   = 24'h000800,
        PH_P0   = 24'h001000,
        PH_P1   = 24'h002000,
        PH_P2   = 24'h004000,
        PH_R0   = 24'h008000,
        PH_R1   = 24'h010000,
        PH_R2   = 24'h020000,
        PH_R3   = 24'h040000,
        PH_R4   = 24'h080000,
        PH_N0   = 24'h100000,
        PH_N1   = 24'h200000,
        PH_N2   = 24'h400000,
        PH_N3   = 24'h800000
    } t_phase;

    typedef struct packed {
        logic [1:0] scl;
        logic [1:0] sda;
        logic       full;
    } t_step;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] tick_count;
        logic [3:0] bit_index;
        logic [2:0] byte_index;
        logic [7:0] shift_byte;
        logic       is_read;
        logic [7:0] target_register;
        logic [7:0] pending_value;
        logic [7:0] received_byte;
        logic       scl;
        logic       sda;
        logic       ack_ok;
    } t_state;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic [7:0] read_data;
        logic       cmd_rejected;
    } t_result;

    // Line actions and wait length of each step
    function automatic t_step step_of(t_phase ph);
        t_step st;
        case (ph)
            PH_S0:   st = '{LV_KEEP, LV_HIGH, 1'b1};
            PH_S1:   st = '{LV_HIGH, LV_KEEP, 1'b1};
            PH_S2:   st = '{LV_KEEP, LV_LOW,  1'b1};
            PH_S3:   st = '{LV_LOW,  LV_KEEP, 1'b0};
            PH_B0:   st = '{LV_KEEP, LV_DATA, 1'b0};
            PH_B1:   st = '{LV_HIGH, LV_KEEP, 1'b1};
            PH_B2:   st = '{LV_LOW,  LV_KEEP, 1'b0};
            PH_A0:   st = '{LV_KEEP, LV_HIGH, 1'b0};
            PH_A1:   st = '{LV_HIGH, LV_KEEP, 1'b1};
            PH_A2:   st = '{LV_LOW,  LV_KEEP, 1'b1};
            PH_A3:   st = '{LV_KEEP, LV_LOW,  1'b1};
            PH_P0:   st = '{LV_KEEP, LV_LOW,  1'b0};
            PH_P1:   st = '{LV_HIGH, LV_KEEP, 1'b1};
            PH_P2:   st = '{LV_KEEP, LV_HIGH, 1'b1};
            PH_R0:   st = '{LV_KEEP, LV_HIGH, 1'b1};
            PH_R1:   st = '{LV_KEEP, LV_KEEP, 1'b0};
            PH_R2:   st = '{LV_HIGH, LV_KEEP, 1'b0};
            PH_R3:   st = '{LV_KEEP, LV_KEEP, 1'b0};
            PH_R4:   st = '{LV_LOW,  LV_KEEP, 1'b0};
            PH_N0:   st = '{LV_KEEP, LV_HIGH, 1'b0};
            PH_N1:   st = '{LV_HIGH, LV_KEEP, 1'b1};
            PH_N2:   st = '{LV_LOW,  LV_KEEP, 1'b1};
            PH_N3:   st = '{LV_KEEP, LV_LOW,  1'b1};
            default: st = '{LV_KEEP, LV_KEEP, 1'b1};
        endcase
        return st;
    endfunction

    // Enter a step: set the lines and load its wait (a zero wait lasts one tick)
    function automatic t_state enter_phase(t_state s, t_phase ph, logic [7:0] ticks);
        t_state     r;
        t_step      st;
        logic [7:0] w;
        r       = s;
        r.phase = ph;
        st      = step_of(ph);
        w       = st.full ? ticks : {1'b0, ticks[7:1]};
        if (ph == PH_IDLE) begin
            r.tick_count = '0;
        end else begin
            if (st.scl != LV_KEEP) r.scl = st.scl[0];
            if (st.sda == LV_DATA) begin
                r.sda = r.shift_byte[7];
            end else if (st.sda != LV_KEEP) begin
                r.sda = st.sda[0];
            end
            r.tick_count = (w != 8'd0) ? w : 8'd1;
        end
        return r;
    endfunction

endpackage

// File: rtl/sccb_in_if.sv
// Interface: input item channel (ticks and commands).
interface sccb_in_if;
    import sccb_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic       sda_in;

    modport source (output valid, output kind, output reg_addr, output write_value,
                    output sda_in, input ready);
    modport sink   (input valid, input kind, input reg_addr, input write_value,
                    input sda_in, output ready);
endinterface

// File: rtl/sccb_out_if.sv
// Interface: result item channel (line levels and status).
interface sccb_out_if;
    import sccb_pkg::*;

    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] read_data;
    logic       cmd_rejected;

    modport source (output valid, output scl_level, output sda_release, output busy_res,
                    output done_res, output success, output read_data,
                    output cmd_rejected, input ready);
    modport sink   (input valid, input scl_level, input sda_release, input busy_res,
                    input done_res, input success, input read_data,
                    input cmd_rejected, output ready);
endinterface

// File: rtl/sccb_step.sv
// Next-state and result logic for one input item of the SCCB master.
module sccb_step (
    input  sccb_pkg::t_state  i_state,
    input  logic [7:0]        i_phase_ticks,
    input  logic [6:0]        i_dev_addr,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_reg_addr,
    input  logic [7:0]        i_write_value,
    input  logic              i_sda_in,
    output sccb_pkg::t_state  o_state,
    output sccb_pkg::t_result o_result
);
    import sccb_pkg::*;

    t_state     nx;
    logic       done;
    logic       rejected;
    logic [3:0] bit_inc;

    assign bit_inc = i_state.bit_index + 4'd1;

    // Advance the bus sequencer by one item
    always_comb begin
        nx       = i_state;
        done     = 1'b0;
        rejected = 1'b0;
        case (i_kind)
            KIND_WRITE, KIND_READ: begin
                if (i_state.phase != PH_IDLE) begin
                    rejected = 1'b1;
                end else begin
                    nx.is_read         = (i_kind == KIND_READ);
                    nx.target_register = i_reg_addr;
                    nx.pending_value   = i_write_value;
                    nx.byte_index      = BYTE_ADDR;
                    nx.bit_index       = '0;
                    nx.ack_ok          = 1'b1;
                    nx.received_byte   = '0;
                    nx = enter_phase(nx, PH_S0, i_phase_ticks);
                end
            end
            KIND_TICK: begin
                if (i_state.phase != PH_IDLE) begin
                    if (i_state.tick_count > 8'd1) begin
                        nx.tick_count = i_state.tick_count - 8'd1;
                    end else begin
                        // Wait over: sample and move to the next step
                        case (i_state.phase)
                            PH_S0: nx = enter_phase(nx, PH_S1, i_phase_ticks);
                            PH_S1: nx = enter_phase(nx, PH_S2, i_phase_ticks);
                            PH_S2: nx = enter_phase(nx, PH_S3, i_phase_ticks);
                            PH_S3: begin
                                nx.bit_index = '0;
                                if (i_state.byte_index == BYTE_VALUE) begin
                                    nx.byte_index = BYTE_RADDR;
                                    nx.shift_byte = {i_dev_addr, 1'b1};
                                end else begin
                                    nx.byte_index = BYTE_ADDR;
                                    nx.shift_byte = {i_dev_addr, 1'b0};
                                end
                                nx = enter_phase(nx, PH_B0, i_phase_ticks);
                            end
                            PH_B0: nx = enter_phase(nx, PH_B1, i_phase_ticks);
                            PH_B1: nx = enter_phase(nx, PH_B2, i_phase_ticks);
                            PH_B2: begin
                                nx.shift_byte = {i_state.shift_byte[6:0], 1'b0};
                                nx.bit_index  = bit_inc;
                                nx = enter_phase(nx, (bit_inc >= BITS_PER_BYTE) ? PH_A0 : PH_B0,
                                                 i_phase_ticks);
                            end
                            PH_A0: nx = enter_phase(nx, PH_A1, i_phase_ticks);
                            PH_A1: begin
                                nx.ack_ok = ~i_sda_in;
                                nx = enter_phase(nx, PH_A2, i_phase_ticks);
                            end
                            PH_A2: nx = enter_phase(nx, PH_A3, i_phase_ticks);
                            PH_A3: begin
                                if (!i_state.ack_ok) begin
                                    nx.byte_index = BYTE_END;
                                    nx = enter_phase(nx, PH_P0, i_phase_ticks);
                                end else if (i_state.byte_index == BYTE_ADDR) begin
                                    nx.byte_index = BYTE_REG;
                                    nx.shift_byte = i_state.target_register;
                                    nx.bit_index  = '0;
                                    nx = enter_phase(nx, PH_B0, i_phase_ticks);
                                end else if (i_state.byte_index == BYTE_REG && !i_state.is_read) begin
                                    nx.byte_index = BYTE_VALUE;
                                    nx.shift_byte = i_state.pending_value;
                                    nx.bit_index  = '0;
                                    nx = enter_phase(nx, PH_B0, i_phase_ticks);
                                end else if (i_state.byte_index == BYTE_REG) begin
                                    nx.byte_index = BYTE_VALUE;
                                    nx = enter_phase(nx, PH_P0, i_phase_ticks);
                                end else if (i_state.byte_index == BYTE_RADDR) begin
                                    nx.bit_index     = '0;
                                    nx.received_byte = '0;
                                    nx = enter_phase(nx, PH_R0, i_phase_ticks);
                                end else begin
                                    nx.byte_index = BYTE_END;
                                    nx = enter_phase(nx, PH_P0, i_phase_ticks);
                                end
                            end
                            PH_P0: nx = enter_phase(nx, PH_P1, i_phase_ticks);
                            PH_P1: nx = enter_phase(nx, PH_P2, i_phase_ticks);
                            PH_P2: begin
                                // Between the two halves of a read: a stop, then a new start
                                if (i_state.is_read && i_state.ack_ok &&
                                    i_state.byte_index == BYTE_VALUE) begin
                                    nx = enter_phase(nx, PH_S0, i_phase_ticks);
                                end else begin
                                    nx   = enter_phase(nx, PH_IDLE, i_phase_ticks);
                                    done = 1'b1;
                                end
                            end
                            PH_R0: nx = enter_phase(nx, PH_R1, i_phase_ticks);
                            PH_R1: nx = enter_phase(nx, PH_R2, i_phase_ticks);
                            PH_R2: begin
                                nx.received_byte = {i_state.received_byte[6:0], i_sda_in};
                                nx = enter_phase(nx, PH_R3, i_phase_ticks);
                            end
                            PH_R3: nx = enter_phase(nx, PH_R4, i_phase_ticks);
                            PH_R4: begin
                                nx.bit_index = bit_inc;
                                nx = enter_phase(nx, (bit_inc >= BITS_PER_BYTE) ? PH_N0 : PH_R1,
                                                 i_phase_ticks);
                            end
                            PH_N0: nx = enter_phase(nx, PH_N1, i_phase_ticks);
                            PH_N1: nx = enter_phase(nx, PH_N2, i_phase_ticks);
                            PH_N2: nx = enter_phase(nx, PH_N3, i_phase_ticks);
                            PH_N3: begin
                                nx.byte_index = BYTE_END;
                                nx = enter_phase(nx, PH_P0, i_phase_ticks);
                            end
                            default: nx = enter_phase(nx, PH_IDLE, i_phase_ticks);
                        endcase
                    end
                end
            end
            default: begin
                nx = i_state;
            end
        endcase
    end

    // Result fields from the updated state
    always_comb begin
        o_state               = nx;
        o_result.scl_level    = nx.scl;
        o_result.sda_release  = nx.sda;
        o_result.busy_res     = (nx.phase != PH_IDLE);
        o_result.done_res     = done;
        o_result.success      = done && nx.ack_ok;
        o_result.read_data    = (done && nx.ack_ok && nx.is_read) ? nx.received_byte : 8'd0;
        o_result.cmd_rejected = rejected;
    end

endmodule

// File: rtl/sccb_register_access_master_core.sv
// Top level: SCCB register access master with item handshakes and config port.
// One input item (a timer tick or a command) is taken per clock while ready is high;
// its result item is held in an output register and appears the cycle after acceptance,
// while the next item may already be accepted. Input ready drops only while the
// output register holds an untaken result. Bus timing is set by tick items: each
// bus step lasts phase_ticks ticks (or half of that), counted in the state register.
module sccb_register_access_master_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sccb_in_if.sink    i_in,
    sccb_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import sccb_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic [7:0] r_phase_ticks;
    logic [6:0] r_dev_addr;
    logic       accept;

    // Handshake: take a new item whenever the output register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    sccb_step u_step (
        .i_state       (r_state),
        .i_phase_ticks (r_phase_ticks),
        .i_dev_addr    (r_dev_addr),
        .i_kind        (i_in.kind),
        .i_reg_addr    (i_in.reg_addr),
        .i_write_value (i_in.write_value),
        .i_sda_in      (i_in.sda_in),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_dev_addr    <= DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                CFG_DEV_ADDR:    r_dev_addr    <= i_cfg_data[6:0];
                default:         r_dev_addr    <= r_dev_addr;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_IDLE;
            r_state.tick_count      <= '0;
            r_state.bit_index       <= '0;
            r_state.byte_index      <= BYTE_ADDR;
            r_state.shift_byte      <= '0;
            r_state.is_read         <= 1'b0;
            r_state.target_register <= '0;
            r_state.pending_value   <= '0;
            r_state.received_byte   <= '0;
            r_state.scl             <= 1'b1;
            r_state.sda             <= 1'b1;
            r_state.ack_ok          <= 1'b1;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scl_level    = r_result.scl_level;
    assign o_out.sda_release  = r_result.sda_release;
    assign o_out.busy_res     = r_result.busy_res;
    assign o_out.done_res     = r_result.done_res;
    assign o_out.success      = r_result.success;
    assign o_out.read_data    = r_result.read_data;
    assign o_out.cmd_rejected = r_result.cmd_rejected;

endmodule

// File: bench/sccb_register_access_master_core_tb.sv
// Testbench: drives ticks and commands into the SCCB master and checks every result item.
module sccb_register_access_master_core_tb;
    import sccb_pkg::*;

    localparam logic [1:0] KIND_SPARE   = 2'd3;   // unused kind, ignored by the block
    localparam logic [2:0] ACK_ALL      = 3'd7;   // slave acknowledges every byte
    localparam int         TOTAL_ITEMS  = 1950;
    localparam int         CYCLE_LIMIT  = 5000000;

    localparam t_result VIEW_IDLE = '{scl_level: 1'b1, sda_release: 1'b1, busy_res: 1'b0,
                                      done_res: 1'b0, success: 1'b0, read_data: 8'h00,
                                      cmd_rejected: 1'b0};
    localparam t_result VIEW_START = '{scl_level: 1'b1, sda_release: 1'b1, busy_res: 1'b1,
                                       done_res: 1'b0, success: 1'b0, read_data: 8'h00,
                                       cmd_rejected: 1'b0};
    localparam t_result VIEW_REJECT = '{scl_level: 1'b1, sda_release: 1'b1, busy_res: 1'b1,
                                        done_res: 1'b0, success: 1'b0, read_data: 8'h00,
                                        cmd_rejected: 1'b1};

    typedef struct {
        logic [1:0] kind;
        logic [7:0] reg_addr;
        logic [7:0] write_value;
        logic       sda_in;
        bit         typed;
        t_result    want;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    sccb_in_if  in_ch ();
    sccb_out_if out_ch ();

    sccb_register_access_master_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Bus model: configuration and transaction state
    logic [7:0] cfg_ticks;
    logic [6:0] cfg_addr;
    t_phase     bus_ph;
    logic [7:0] bus_wait;
    logic [3:0] bus_bit;
    logic [2:0] bus_byte;
    logic [7:0] bus_shift;
    logic       bus_rd;
    logic [7:0] bus_reg;
    logic [7:0] bus_val;
    logic [7:0] bus_rx;
    logic       bus_scl;
    logic       bus_sda;
    logic       bus_ack;

    // Slave behavior for the current transaction
    logic [2:0] slave_nack_at;
    bit         slave_rnd_nack;
    logic [7:0] slave_byte;

    t_result    line_view_q[$];
    t_dir_row   dir_tab[$];
    t_result    got_want;
    bit         tx_calm;
    int         err_count;
    int         cycle_count;
    int         items_sent;
    int         n_done;
    int         n_ok;
    int         n_reads;
    int         n_rej;
    int         n_settings;

    // Enter a bus step: drive the lines and load its wait
    function automatic void bus_enter(t_phase ph);
        logic [1:0] scl_act;
        logic [1:0] sda_act;
        logic       full;
        logic [7:0] w;
        bus_ph = ph;
        if (ph == PH_IDLE) begin
            bus_wait = 8'd0;
            return;
        end
        case (ph)
            PH_S0:   {scl_act, sda_act, full} = {LV_KEEP, LV_HIGH, 1'b1};
            PH_S1:   {scl_act, sda_act, full} = {LV_HIGH, LV_KEEP, 1'b1};
            PH_S2:   {scl_act, sda_act, full} = {LV_KEEP, LV_LOW,  1'b1};
            PH_S3:   {scl_act, sda_act, full} = {LV_LOW,  LV_KEEP, 1'b0};
            PH_B0:   {scl_act, sda_act, full} = {LV_KEEP, LV_DATA, 1'b0};
            PH_B1:   {scl_act, sda_act, full} = {LV_HIGH, LV_KEEP, 1'b1};
            PH_B2:   {scl_act, sda_act, full} = {LV_LOW,  LV_KEEP, 1'b0};
            PH_A0:   {scl_act, sda_act, full} = {LV_KEEP, LV_HIGH, 1'b0};
            PH_A1:   {scl_act, sda_act, full} = {LV_HIGH, LV_KEEP, 1'b1};
            PH_A2:   {scl_act, sda_act, full} = {LV_LOW,  LV_KEEP, 1'b1};
            PH_A3:   {scl_act, sda_act, full} = {LV_KEEP, LV_LOW,  1'b1};
            PH_P0:   {scl_act, sda_act, full} = {LV_KEEP, LV_LOW,  1'b0};
            PH_P1:   {scl_act, sda_act, full} = {LV_HIGH, LV_KEEP, 1'b1};
            PH_P2:   {scl_act, sda_act, full} = {LV_KEEP, LV_HIGH, 1'b1};
            PH_R0:   {scl_act, sda_act, full} = {LV_KEEP, LV_HIGH, 1'b1};
            PH_R1:   {scl_act, sda_act, full} = {LV_KEEP, LV_KEEP, 1'b0};
            PH_R2:   {scl_act, sda_act, full} = {LV_HIGH, LV_KEEP, 1'b0};
            PH_R3:   {scl_act, sda_act, full} = {LV_KEEP, LV_KEEP, 1'b0};
            PH_R4:   {scl_act, sda_act, full} = {LV_LOW,  LV_KEEP, 1'b0};
            PH_N0:   {scl_act, sda_act, full} = {LV_KEEP, LV_HIGH, 1'b0};
            PH_N1:   {scl_act, sda_act, full} = {LV_HIGH, LV_KEEP, 1'b1};
            PH_N2:   {scl_act, sda_act, full} = {LV_LOW,  LV_KEEP, 1'b1};
            default: {scl_act, sda_act, full} = {LV_KEEP, LV_LOW,  1'b1};
        endcase
        if (scl_act != LV_KEEP) bus_scl = scl_act[0];
        if (sda_act == LV_DATA) begin
            bus_sda = bus_shift[7];
        end else if (sda_act != LV_KEEP) begin
            bus_sda = sda_act[0];
        end
        w        = full ? cfg_ticks : (cfg_ticks >> 1);
        bus_wait = (w != 8'd0) ? w : 8'd1;
    endfunction

    function automatic void bus_load_byte(logic [7:0] b);
        bus_shift = b;
        bus_bit   = 4'd0;
        bus_enter(PH_B0);
    endfunction

    // Close the current step on the tick that ends its wait; 1 when the transaction ends
    function automatic bit bus_end_step(logic s);
        logic [7:0] wr;
        bit         fin;
        wr  = {cfg_addr, 1'b0};
        fin = 1'b0;
        case (bus_ph)
            PH_S3: begin
                if (bus_byte == BYTE_VALUE) begin
                    bus_byte = BYTE_RADDR;
                    bus_load_byte(wr | 8'd1);
                end else begin
                    bus_byte = BYTE_ADDR;
                    bus_load_byte(wr);
                end
            end
            PH_B2: begin
                bus_shift = bus_shift << 1;
                bus_bit   = bus_bit + 4'd1;
                bus_enter((bus_bit >= BITS_PER_BYTE) ? PH_A0 : PH_B0);
            end
            PH_A1: begin
                bus_ack = ~s;
                bus_enter(PH_A2);
            end
            PH_A3: begin
                if (!bus_ack) begin
                    bus_byte = BYTE_END;
                    bus_enter(PH_P0);
                end else if (bus_byte == BYTE_ADDR) begin
                    bus_byte = BYTE_REG;
                    bus_load_byte(bus_reg);
                end else if (bus_byte == BYTE_REG && !bus_rd) begin
                    bus_byte = BYTE_VALUE;
                    bus_load_byte(bus_val);
                end else if (bus_byte == BYTE_REG) begin
                    bus_byte = BYTE_VALUE;
                    bus_enter(PH_P0);
                end else if (bus_byte == BYTE_RADDR) begin
                    bus_bit = 4'd0;
                    bus_rx  = 8'd0;
                    bus_enter(PH_R0);
                end else begin
                    bus_byte = BYTE_END;
                    bus_enter(PH_P0);
                end
            end
            PH_P2: begin
                // a read restarts after its register phase, everything else ends here
                if (bus_rd && bus_ack && bus_byte == BYTE_VALUE) begin
                    bus_enter(PH_S0);
                end else begin
                    bus_enter(PH_IDLE);
                    fin = 1'b1;
                end
            end
            PH_R2: begin
                bus_rx = {bus_rx[6:0], s};
                bus_enter(PH_R3);
            end
            PH_R4: begin
                bus_bit = bus_bit + 4'd1;
                bus_enter((bus_bit >= BITS_PER_BYTE) ? PH_N0 : PH_R1);
            end
            PH_N3: begin
                bus_byte = BYTE_END;
                bus_enter(PH_P0);
            end
            default: begin
                bus_enter(bus_ph.next());
            end
        endcase
        return fin;
    endfunction

    // Line levels and status that one accepted item leaves behind
    function automatic t_result predict_line_view(logic [1:0] k, logic [7:0] ra,
                                                  logic [7:0] wv, logic s);
        t_result r;
        bit      fin;
        bit      rej;
        fin = 1'b0;
        rej = 1'b0;
        if (k == KIND_WRITE || k == KIND_READ) begin
            if (bus_ph != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                bus_rd   = (k == KIND_READ);
                bus_reg  = ra;
                bus_val  = wv;
                bus_byte = BYTE_ADDR;
                bus_bit  = 4'd0;
                bus_ack  = 1'b1;
                bus_rx   = 8'd0;
                bus_enter(PH_S0);
            end
        end else if (k == KIND_TICK && bus_ph != PH_IDLE) begin
            if (bus_wait > 8'd1) bus_wait = bus_wait - 8'd1;
            else fin = bus_end_step(s);
        end
        r.scl_level    = bus_scl;
        r.sda_release  = bus_sda;
        r.busy_res     = (bus_ph != PH_IDLE);
        r.done_res     = fin;
        r.success      = fin && bus_ack;
        r.read_data    = (fin && bus_ack && bus_rd) ? bus_rx : 8'd0;
        r.cmd_rejected = rej;
        return r;
    endfunction

    // Data line level the camera presents on the next tick
    function automatic logic slave_sda();
        if (bus_ph == PH_A1) begin
            return (bus_byte == slave_nack_at) ||
                   (slave_rnd_nack && $urandom_range(0, 5) == 0);
        end
        if (bus_ph == PH_R2) return slave_byte[3'd7 - bus_bit[2:0]];
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void tab_row(logic [1:0] k, logic [7:0] ra, logic [7:0] wv,
                                    logic s, bit typed, t_result want);
        t_dir_row row;
        row.kind        = k;
        row.reg_addr    = ra;
        row.write_value = wv;
        row.sda_in      = s;
        row.typed       = typed;
        row.want        = want;
        dir_tab.push_back(row);
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // Offer one item, wait for it to be taken, then record what it should produce
    task automatic put_item(logic [1:0] k, logic [7:0] ra, logic [7:0] wv, logic s,
                            bit typed, t_result want);
        int      gap;
        t_result view;
        gap = tx_calm ? 0 : sender_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= k;
        in_ch.reg_addr    <= ra;
        in_ch.write_value <= wv;
        in_ch.sda_in      <= s;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        view = predict_line_view(k, ra, wv, s);
        line_view_q.push_back(typed ? want : view);
        items_sent++;
    endtask

    task automatic put_tick();
        put_item(KIND_TICK, 8'($urandom), 8'($urandom), slave_sda(), 1'b0, VIEW_IDLE);
    endtask

    // Tick the bus until the transaction ends, with stray commands in between
    task automatic finish_xfer();
        int r;
        while (bus_ph != PH_IDLE) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                put_item($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, 8'($urandom),
                         8'($urandom), 1'($urandom), 1'b0, VIEW_IDLE);
            end else if (r < 5) begin
                put_item(KIND_SPARE, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0,
                         VIEW_IDLE);
            end else begin
                put_tick();
            end
        end
    endtask

    task automatic run_xfer(logic [1:0] k, logic [7:0] ra, logic [7:0] wv,
                            logic [2:0] nack_at, bit rnd_nack, logic [7:0] rbyte);
        int idle_n;
        slave_nack_at  = nack_at;
        slave_rnd_nack = rnd_nack;
        slave_byte     = rbyte;
        put_item(k, ra, wv, 1'($urandom), 1'b0, VIEW_IDLE);
        finish_xfer();
        idle_n = $urandom_range(0, 2);
        repeat (idle_n) put_tick();
    endtask

    // Wait until every result is in, then rewrite both registers
    task automatic configure(logic [7:0] ticks, logic [6:0] addr);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (line_view_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PHASE_TICKS;
        i_cfg_data <= ticks;
        @(posedge i_clk);
        cfg_ticks  = ticks;
        i_cfg_idx  <= CFG_DEV_ADDR;
        i_cfg_data <= {1'b0, addr};
        @(posedge i_clk);
        cfg_addr   = addr;
        i_cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // A read that ended well carries its byte; zero is ambiguous, so count nonzero ones
    function automatic bit bus_rd_seen(t_result v);
        return v.read_data != 8'd0;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter and run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sccb_register_access_master_core_tb: FAIL");
            $finish;
        end
    end

    // Result side: random stalls, with calm stretches now and then
    initial begin
        int stall;
        int mode_cnt;
        int r;
        bit calm;
        stall    = 0;
        mode_cnt = 0;
        calm     = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            mode_cnt++;
            if (mode_cnt == 300) begin
                mode_cnt = 0;
                calm     = ($urandom_range(0, 3) == 0);
            end
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                r     = $urandom_range(0, 99);
                stall = (r < 70) ? $urandom_range(0, 1) :
                        (r < 95) ? $urandom_range(2, 7) : $urandom_range(19, 49);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Result checker: each taken item against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (line_view_q.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                got_want = line_view_q.pop_front();
                check_field("scl_level",    8'(out_ch.scl_level),    8'(got_want.scl_level));
                check_field("sda_release",  8'(out_ch.sda_release),
                            8'(got_want.sda_release));
                check_field("busy_res",     8'(out_ch.busy_res),     8'(got_want.busy_res));
                check_field("done_res",     8'(out_ch.done_res),     8'(got_want.done_res));
                check_field("success",      8'(out_ch.success),      8'(got_want.success));
                check_field("read_data",    out_ch.read_data,        got_want.read_data);
                check_field("cmd_rejected", 8'(out_ch.cmd_rejected),
                            8'(got_want.cmd_rejected));
                if (got_want.done_res) n_done++;
                if (got_want.success) n_ok++;
                if (got_want.success && bus_rd_seen(got_want)) n_reads++;
                if (got_want.cmd_rejected) n_rej++;
            end
        end
    end

    // Stimulus
    initial begin
        int r;
        int nx;
        logic [7:0] pt;
        logic [6:0] da;
        logic [2:0] nack;
        bit rnd;

        in_ch.valid       <= 1'b0;
        in_ch.kind        <= KIND_TICK;
        in_ch.reg_addr    <= 8'd0;
        in_ch.write_value <= 8'd0;
        in_ch.sda_in      <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_PHASE_TICKS;
        i_cfg_data        <= 8'd0;
        i_rst_n           <= 1'b0;

        items_sent  = 0;
        n_settings  = 0;
        tx_calm     = 1'b0;
        cfg_ticks   = PHASE_TICKS_RST;
        cfg_addr    = DEV_ADDR_RST;
        bus_ph      = PH_IDLE;
        bus_wait    = 8'd0;
        bus_bit     = 4'd0;
        bus_byte    = BYTE_ADDR;
        bus_shift   = 8'd0;
        bus_rd      = 1'b0;
        bus_reg     = 8'd0;
        bus_val     = 8'd0;
        bus_rx      = 8'd0;
        bus_scl     = 1'b1;
        bus_sda     = 1'b1;
        bus_ack     = 1'b1;
        slave_nack_at  = ACK_ALL;
        slave_rnd_nack = 1'b0;
        slave_byte     = 8'd0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: idle ticks, spare kind, start, busy rejects, first bus steps
        tab_row(KIND_TICK,  8'h00, 8'h00, 1'b0, 1'b1, VIEW_IDLE);
        tab_row(KIND_TICK,  8'hFF, 8'hFF, 1'b1, 1'b1, VIEW_IDLE);
        tab_row(KIND_SPARE, 8'hFF, 8'hFF, 1'b1, 1'b1, VIEW_IDLE);
        tab_row(KIND_WRITE, 8'hFF, 8'h00, 1'b0, 1'b1, VIEW_START);
        tab_row(KIND_READ,  8'h00, 8'hFF, 1'b1, 1'b1, VIEW_REJECT);
        tab_row(KIND_WRITE, 8'h00, 8'hFF, 1'b0, 1'b1, VIEW_REJECT);
        tab_row(KIND_SPARE, 8'h00, 8'h00, 1'b0, 1'b1, VIEW_START);
        for (int i = 0; i < 12; i++) begin
            tab_row(KIND_TICK, 8'(i * 37), 8'(~(i * 37)), 1'(i), 1'b0, VIEW_IDLE);
        end
        foreach (dir_tab[i]) begin
            put_item(dir_tab[i].kind, dir_tab[i].reg_addr, dir_tab[i].write_value,
                     dir_tab[i].sda_in, dir_tab[i].typed, dir_tab[i].want);
        end
        finish_xfer();

        // Whole transactions at reset settings: a full read and an address not-acknowledge
        run_xfer(KIND_READ,  8'h5A, 8'h00, ACK_ALL,    1'b0, 8'hFF);
        run_xfer(KIND_WRITE, 8'h3C, 8'hC3, BYTE_ADDR,  1'b0, 8'h00);

        // Zero waits: data extremes and the other not-acknowledge spots
        configure(8'd0, 7'd0);
        run_xfer(KIND_WRITE, 8'h00, 8'hFF, ACK_ALL,    1'b0, 8'h00);
        run_xfer(KIND_READ,  8'hA5, 8'hFF, ACK_ALL,    1'b0, 8'h00);
        run_xfer(KIND_READ,  8'h7E, 8'h81, ACK_ALL,    1'b0, 8'hC5);
        run_xfer(KIND_READ,  8'h11, 8'h00, BYTE_REG,   1'b0, 8'h00);
        run_xfer(KIND_WRITE, 8'h22, 8'h44, BYTE_VALUE, 1'b0, 8'h00);
        run_xfer(KIND_READ,  8'h33, 8'h00, BYTE_RADDR, 1'b0, 8'h81);

        // One-tick full wait, the smallest wait whose half step is not zero, and an odd wait
        configure(8'd1, 7'd127);
        run_xfer(KIND_WRITE, 8'hFF, 8'h00, BYTE_ADDR, 1'b0, 8'h00);
        configure(8'd2, 7'h55);
        run_xfer(KIND_WRITE, 8'h12, 8'h34, ACK_ALL, 1'b0, 8'h00);
        configure(8'd3, 7'd127);
        run_xfer(KIND_WRITE, 8'hF0, 8'h0F, BYTE_ADDR, 1'b0, 8'h00);

        // Random settings, each with a few transactions of random content
        while (items_sent < TOTAL_ITEMS) begin
            r  = $urandom_range(0, 9);
            pt = (r < 3) ? 8'($urandom_range(0, 1)) :
                 (r < 7) ? 8'($urandom_range(2, 3)) :
                 (r < 9) ? 8'($urandom_range(4, 6)) : 8'($urandom_range(7, 8));
            r  = $urandom_range(0, 7);
            da = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom);
            configure(pt, da);
            nx = $urandom_range(2, 4);
            for (int t = 0; t < nx && items_sent < TOTAL_ITEMS; t++) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                r       = $urandom_range(0, 99);
                nack    = (r < 85) ? ACK_ALL : 3'($urandom_range(0, 3));
                rnd     = (r >= 70 && r < 85);
                run_xfer($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, 8'($urandom),
                         8'($urandom), nack, rnd, 8'($urandom));
            end
            tx_calm = 1'b0;
        end

        // Drain and report
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (line_view_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("run covered %0d items over %0d register settings, %0d stray commands refused",
                 items_sent, n_settings, n_rej);
        $display("%0d transactions ended, %0d fully acknowledged, %0d reads with nonzero data",
                 n_done, n_ok, n_reads);
        if (err_count == 0) begin
            $display("sccb_register_access_master_core_tb: PASS");
        end else begin
            $display("%0d mismatches", err_count);
            $display("sccb_register_access_master_core_tb: FAIL");
        end
        $finish;
    end

endmodule
